@@ rtl/bat_pkg.sv @@
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types, constants and character-class helpers for the bracket-aware
// tokenizer.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int MAX_DELIMITERS = 8;
	localparam int MAX_STRING_LEN = 65536;
	localparam logic [15:0] POS_LIMIT = (MAX_STRING_LEN < 65535) ?
		16'(MAX_STRING_LEN) : 16'hFFFF;

	localparam logic [7:0]  BACKSLASH           = 8'h5C;
	localparam logic [63:0] DEFAULT_DELIMS      = 64'h0000_000C_0D0A_0920;
	localparam logic [3:0]  DEFAULT_DELIM_COUNT = 4'd5;

	// register reset values
	localparam logic [63:0] DELIM_SET_RST   = 64'h0000_000C_0D0A_0920;
	localparam logic [3:0]  DELIM_COUNT_RST = 4'd5;
	localparam logic [63:0] BRACKET_RST     = 64'h0000_0000_0000_2928;
	localparam logic [2:0]  PAIR_COUNT_RST  = 3'd1;
	localparam logic [31:0] QUOTE_RST       = 32'h0000_0022;
	localparam logic [2:0]  QUOTE_COUNT_RST = 3'd1;

	// register indexes
	localparam logic [2:0] REG_DELIM_SET   = 3'd0;
	localparam logic [2:0] REG_DELIM_COUNT = 3'd1;
	localparam logic [2:0] REG_BRACKETS    = 3'd2;
	localparam logic [2:0] REG_PAIR_COUNT  = 3'd3;
	localparam logic [2:0] REG_QUOTE_SET   = 3'd4;
	localparam logic [2:0] REG_QUOTE_COUNT = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_UNMATCHED     = 2'd0;
	localparam logic [1:0] ERR_OPEN_QUOTE    = 2'd1;
	localparam logic [1:0] ERR_OPEN_BRACKET  = 2'd2;
	localparam logic [1:0] ERR_TOO_DEEP      = 2'd3;

	typedef struct packed {
		logic [63:0] delim_set;
		logic [3:0]  delim_count;
		logic [63:0] bracket_pairs;
		logic [2:0]  pair_count;
		logic [31:0] quote_set;
		logic [2:0]  quote_count;
	} cfg_t;

	typedef struct packed {
		logic       delim;
		logic       quote;
		logic       br_found;
		logic [2:0] br_pos;
	} class_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [15:0] tstart;
		logic [15:0] tend;
		logic [1:0]  err;
	} res_t;

	typedef struct packed {
		logic        in_token;
		logic [7:0]  open_quote;
		logic        esc;
		logic [15:0] byte_pos;
		logic [15:0] start_pos;
		logic        drain;
	} state_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] val;
	} stack_op_t;

	function automatic logic [7:0] byte_of(logic [63:0] w, logic [2:0] i);
		return w[{i, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] pair_opener(logic [63:0] pairs, logic [1:0] p);
		return byte_of(pairs, {p, 1'b0});
	endfunction

	function automatic class_t classify(logic [7:0] c, cfg_t cfg);
		class_t cl;
		logic [63:0] dset;
		logic [3:0] dn;
		logic [2:0] qn;
		logic [3:0] bn;
		cl = '0;
		dset = cfg.delim_set;
		dn = cfg.delim_count;
		if (dn == 4'd0) begin
			dset = DEFAULT_DELIMS;
			dn = DEFAULT_DELIM_COUNT;
		end
		if (dn > 4'(MAX_DELIMITERS))
			dn = 4'(MAX_DELIMITERS);
		qn = (cfg.quote_count > 3'd4) ? 3'd4 : cfg.quote_count;
		bn = (cfg.pair_count > 3'd4) ? 4'd8 : {cfg.pair_count, 1'b0};
		if (c != 8'd0) begin
			for (int i = 0; i < 8; i++) begin
				if (4'(i) < dn && byte_of(dset, 3'(i)) == c)
					cl.delim = 1'b1;
			end
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < qn && cfg.quote_set[8*i +: 8] == c)
					cl.quote = 1'b1;
			end
			// lowest position wins
			for (int i = 0; i < 8; i++) begin
				if (!cl.br_found && 4'(i) < bn && byte_of(cfg.bracket_pairs, 3'(i)) == c) begin
					cl.br_found = 1'b1;
					cl.br_pos = 3'(i);
				end
			end
		end
		return cl;
	endfunction

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] value, logic [15:0] s,
		logic [15:0] e, logic [1:0] err);
		res_t r;
		r.kind = kind;
		r.value = value;
		r.tstart = s;
		r.tend = e;
		r.err = err;
		return r;
	endfunction

endpackage

@@ rtl/bracket_aware_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// bracket_aware_tokenizer_unit
// Splits a byte stream into tokens at delimiters, honoring quotes, nested
// bracket pairs and backslash escapes.
// Input channel (in_valid / in_stall) carries one byte per beat with an
// end_of_string flag. Output channel (out_valid / out_stall) carries one
// result per beat: token byte, token end with offsets, or error; last_of_run
// marks the final result caused by one input byte. A byte may cause zero to
// three results.
// A byte is registered in the input register, then processed combinationally
// into the result register, which presents its results on the output.
// Throughput: one byte per cycle while each byte yields at most one result
// and the output does not stall; a byte that yields more than one result
// holds the input until the single output port has drained the result
// register. Bytes that yield no result never wait on the output side.
// Reset clears the parse state and loads the default delimiter, bracket and
// quote sets. A stalled receiver holds the current result; the input stalls
// once the input register is full and its results have nowhere to go.
// Configuration writes take effect immediately; write only while idle.
// ----------------------------------------------------------------------------
module bracket_aware_tokenizer_unit #(
	parameter int MAX_NESTING = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [15:0] token_start,
	output logic [15:0] token_end,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	localparam int DW = $clog2(MAX_NESTING + 1);

	bat_pkg::cfg_t          cfg_q;
	bat_pkg::state_t        st_q;
	bat_pkg::state_t        st_next;
	bat_pkg::stack_op_t     op;
	bat_pkg::res_t [2:0]    res;
	bat_pkg::res_t [2:0]    res_s2;
	bat_pkg::res_t          cur;
	logic [1:0]             res_count;
	logic [1:0]             count_s2;
	logic [1:0]             ptr_s2;
	logic                   valid_s2;
	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   eos_s1;
	logic [DW-1:0]          depth;
	logic [DW-1:0]          depth_next;
	logic [1:0]             top_pair;
	logic                   go;
	logic                   in_acc;
	logic                   out_acc;
	logic                   last;
	logic                   s2_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_set     <= bat_pkg::DELIM_SET_RST;
			cfg_q.delim_count   <= bat_pkg::DELIM_COUNT_RST;
			cfg_q.bracket_pairs <= bat_pkg::BRACKET_RST;
			cfg_q.pair_count    <= bat_pkg::PAIR_COUNT_RST;
			cfg_q.quote_set     <= bat_pkg::QUOTE_RST;
			cfg_q.quote_count   <= bat_pkg::QUOTE_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bat_pkg::REG_DELIM_SET:   cfg_q.delim_set     <= cfg_data;
				bat_pkg::REG_DELIM_COUNT: cfg_q.delim_count   <= cfg_data[3:0];
				bat_pkg::REG_BRACKETS:    cfg_q.bracket_pairs <= cfg_data;
				bat_pkg::REG_PAIR_COUNT:  cfg_q.pair_count    <= cfg_data[2:0];
				bat_pkg::REG_QUOTE_SET:   cfg_q.quote_set     <= cfg_data[31:0];
				bat_pkg::REG_QUOTE_COUNT: cfg_q.quote_count   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign last     = (ptr_s2 == count_s2 - 2'd1);
	assign out_acc  = valid_s2 && !out_stall;
	assign s2_free  = !valid_s2 || (out_acc && last);
	assign go       = valid_s1 && ((res_count == 2'd0) || s2_free);
	assign in_stall = valid_s1 && !go;
	assign in_acc   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
	end

	bat_step #(
		.MAX_NESTING(MAX_NESTING)
	) u_step (
		.cfg        (cfg_q),
		.char_code  (char_s1),
		.eos        (eos_s1),
		.st         (st_q),
		.depth      (depth),
		.top_pair   (top_pair),
		.st_next    (st_next),
		.depth_next (depth_next),
		.op         (op),
		.res        (res),
		.res_count  (res_count)
	);

	bat_stack #(
		.MAX_NESTING(MAX_NESTING)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (go),
		.depth_next (depth_next),
		.op         (op),
		.depth      (depth),
		.top        (top_pair)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (go) begin
			st_q <= st_next;
		end
	end

	// result register, drained one beat at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			count_s2 <= 2'd0;
			ptr_s2   <= 2'd0;
		end else if (go && res_count != 2'd0) begin
			valid_s2 <= 1'b1;
			count_s2 <= res_count;
			ptr_s2   <= 2'd0;
		end else if (out_acc) begin
			if (last)
				valid_s2 <= 1'b0;
			else
				ptr_s2 <= ptr_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_count != 2'd0)
			res_s2 <= res;
	end

	assign cur         = res_s2[ptr_s2];
	assign out_valid   = valid_s2;
	assign kind        = cur.kind;
	assign value       = cur.value;
	assign token_start = cur.tstart;
	assign token_end   = cur.tend;
	assign error_code  = cur.err;
	assign last_of_run = last;

endmodule

@@ rtl/bat_stack.sv @@
// ----------------------------------------------------------------------------
// bat_stack
// Bracket stack: top and next entries in flops, deeper entries in a small
// memory with a registered read that is always prefetching the entry that
// becomes "next" on a pop.
// ----------------------------------------------------------------------------
module bat_stack #(
	parameter int MAX_NESTING = 16,
	localparam int DW = $clog2(MAX_NESTING + 1),
	localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [DW-1:0]          depth_next,
	input  bat_pkg::stack_op_t     op,
	output logic [DW-1:0]          depth,
	output logic [1:0]             top
);

	logic [1:0]    mem [MAX_NESTING];
	logic [1:0]    top_q;
	logic [1:0]    next_q;
	logic [1:0]    rd_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_nx;
	logic [DW-1:0] slot;
	logic [AW-1:0] addr;
	logic          wr;

	// entries 0 .. depth-3 live in mem, depth-2 in next_q, depth-1 in top_q
	assign depth_nx = en ? depth_next : depth_q;
	assign slot     = depth_nx - DW'(3);
	assign addr     = AW'(slot);
	assign wr       = en && op.push && (depth_nx >= DW'(3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem[addr] <= next_q;
		// on a push the new prefetch target is the entry being written
		if (en && op.push)
			rd_q <= next_q;
		else
			rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (op.push) begin
				top_q  <= op.val;
				next_q <= top_q;
			end else if (op.pop) begin
				top_q  <= next_q;
				next_q <= rd_q;
			end
		end
	end

	assign depth = depth_q;
	assign top   = top_q;

endmodule

@@ rtl/bat_step.sv @@
// ----------------------------------------------------------------------------
// bat_step
// Next-state and result logic for one input byte: escape resolution, quote
// and bracket tracking, token boundaries and end-of-string checks. Up to
// three results per byte.
// ----------------------------------------------------------------------------
module bat_step #(
	parameter int MAX_NESTING = 16,
	localparam int DW = $clog2(MAX_NESTING + 1)
) (
	input  bat_pkg::cfg_t          cfg,
	input  logic [7:0]             char_code,
	input  logic                   eos,
	input  bat_pkg::state_t        st,
	input  logic [DW-1:0]          depth,
	input  logic [1:0]             top_pair,
	output bat_pkg::state_t        st_next,
	output logic [DW-1:0]          depth_next,
	output bat_pkg::stack_op_t     op,
	output bat_pkg::res_t [2:0]    res,
	output logic [1:0]             res_count
);

	typedef struct packed {
		bat_pkg::state_t      st;
		logic [DW-1:0]        depth;
		bat_pkg::stack_op_t   op;
		bat_pkg::res_t [2:0]  res;
		logic [1:0]           n;
	} ctx_t;

	function automatic ctx_t emit(ctx_t x, bat_pkg::res_t r);
		ctx_t y;
		y = x;
		y.res[y.n] = r;
		y.n = y.n + 2'd1;
		return y;
	endfunction

	function automatic ctx_t fail(ctx_t x, logic [1:0] code);
		ctx_t y;
		y = emit(x, bat_pkg::mk_res(bat_pkg::KIND_ERROR, 8'd0, 16'd0, 16'd0, code));
		y.st.drain = 1'b1;
		return y;
	endfunction

	function automatic ctx_t process(ctx_t x, logic [7:0] c, bat_pkg::class_t cl,
		logic [15:0] idx, logic may_defer, logic [63:0] pairs, logic [1:0] tp);
		ctx_t y;
		logic skip;
		logic done;
		y = x;
		skip = 1'b0;
		done = 1'b0;
		if (!y.st.in_token) begin
			if (cl.delim) begin
				skip = 1'b1;
			end else begin
				y.st.in_token = 1'b1;
				y.st.start_pos = idx;
				y.st.open_quote = 8'd0;
				y.depth = '0;
			end
		end
		if (!skip) begin
			if (c == bat_pkg::BACKSLASH && may_defer) begin
				y.st.esc = 1'b1;
			end else begin
				if (y.st.open_quote != 8'd0) begin
					if (c == y.st.open_quote)
						y.st.open_quote = 8'd0;
				end else if (cl.quote) begin
					y.st.open_quote = c;
				end else if (cl.br_found) begin
					if (!cl.br_pos[0]) begin
						if (y.depth >= DW'(MAX_NESTING)) begin
							y = fail(y, bat_pkg::ERR_TOO_DEEP);
							done = 1'b1;
						end else begin
							y.op.push = 1'b1;
							y.op.val = cl.br_pos[2:1];
							y.depth = y.depth + DW'(1);
						end
					end else begin
						if (y.depth == '0 || bat_pkg::pair_opener(pairs, tp) !=
							bat_pkg::pair_opener(pairs, cl.br_pos[2:1])) begin
							y = fail(y, bat_pkg::ERR_UNMATCHED);
							done = 1'b1;
						end else begin
							y.op.pop = 1'b1;
							y.depth = y.depth - DW'(1);
						end
					end
				end
				if (!done) begin
					if (y.depth == '0 && y.st.open_quote == 8'd0 && cl.delim) begin
						y = emit(y, bat_pkg::mk_res(bat_pkg::KIND_END, 8'd0, y.st.start_pos,
							idx, 2'd0));
						y.st.in_token = 1'b0;
					end else begin
						y = emit(y, bat_pkg::mk_res(bat_pkg::KIND_CHAR, c, 16'd0, 16'd0, 2'd0));
					end
				end
			end
		end
		return y;
	endfunction

	always_comb begin
		ctx_t x;
		bat_pkg::class_t cl;
		bat_pkg::class_t bcl;
		logic [15:0] idx;
		logic [15:0] bs_idx;
		logic escapable;

		cl  = bat_pkg::classify(char_code, cfg);
		bcl = bat_pkg::classify(bat_pkg::BACKSLASH, cfg);
		idx = st.byte_pos;
		if (st.byte_pos >= bat_pkg::POS_LIMIT)
			bs_idx = bat_pkg::POS_LIMIT;
		else if (st.byte_pos == 16'd0)
			bs_idx = 16'd0;
		else
			bs_idx = st.byte_pos - 16'd1;
		escapable = (char_code == bat_pkg::BACKSLASH) || cl.quote || cl.br_found || cl.delim;

		x = '0;
		x.st = st;
		x.depth = depth;
		if (st.byte_pos < bat_pkg::POS_LIMIT)
			x.st.byte_pos = st.byte_pos + 16'd1;

		if (!st.drain) begin
			if (st.esc) begin
				x.st.esc = 1'b0;
				if (escapable) begin
					if (x.st.open_quote != 8'd0)
						x = emit(x, bat_pkg::mk_res(bat_pkg::KIND_CHAR, bat_pkg::BACKSLASH,
							16'd0, 16'd0, 2'd0));
					x = emit(x, bat_pkg::mk_res(bat_pkg::KIND_CHAR, char_code, 16'd0, 16'd0,
						2'd0));
				end else begin
					// stale backslash is an ordinary byte, then this byte
					x = process(x, bat_pkg::BACKSLASH, bcl, bs_idx, 1'b0,
						cfg.bracket_pairs, top_pair);
					if (!x.st.drain)
						x = process(x, char_code, cl, idx, !eos, cfg.bracket_pairs, top_pair);
				end
			end else begin
				x = process(x, char_code, cl, idx, !eos, cfg.bracket_pairs, top_pair);
			end
			if (eos && !x.st.drain && x.st.in_token) begin
				if (x.st.open_quote != 8'd0)
					x = emit(x, bat_pkg::mk_res(bat_pkg::KIND_ERROR, 8'd0, 16'd0, 16'd0,
						bat_pkg::ERR_OPEN_QUOTE));
				else if (x.depth != '0)
					x = emit(x, bat_pkg::mk_res(bat_pkg::KIND_ERROR, 8'd0, 16'd0, 16'd0,
						bat_pkg::ERR_OPEN_BRACKET));
				else
					x = emit(x, bat_pkg::mk_res(bat_pkg::KIND_END, 8'd0, x.st.start_pos,
						x.st.byte_pos, 2'd0));
			end
		end

		if (eos) begin
			x.st = '0;
			x.depth = '0;
		end

		st_next    = x.st;
		depth_next = x.depth;
		op         = x.op;
		res        = x.res;
		res_count  = x.n;
	end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bracket_aware_tokenizer_unit. Strings go in one
// byte per beat. A cycle-free model of the parser (quotes, nested brackets,
// late-resolved escapes, error drain, saturating offsets) predicts every
// result beat, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NEST = 16;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 78;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [15:0] tstart;
		logic [15:0] tend;
		logic [1:0]  err;
		logic        last;
	} token_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = '0;
	logic        end_of_string = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [15:0] token_start;
	logic [15:0] token_end;
	logic [1:0]  error_code;
	logic        last_of_run;

	bracket_aware_tokenizer_unit #(
		.MAX_NESTING(NEST)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.token_start(token_start),
		.token_end(token_end),
		.error_code(error_code),
		.last_of_run(last_of_run)
	);

	// register mirror and parser state of the model
	bat_pkg::cfg_t tok_cfg = bat_pkg::cfg_t'{bat_pkg::DELIM_SET_RST, bat_pkg::DELIM_COUNT_RST,
		bat_pkg::BRACKET_RST, bat_pkg::PAIR_COUNT_RST, bat_pkg::QUOTE_RST,
		bat_pkg::QUOTE_COUNT_RST};
	bit         in_tok;
	logic [7:0] quote_open;
	bit [1:0]   nest_stack [NEST];
	int         nest_depth;
	bit         esc_wait;
	int         pos_count;
	int         tok_start;
	bit         draining;

	token_result_t token_results_due[$];
	token_result_t beat_results[$];
	logic [7:0]    string_bytes[$];
	int            mismatches;
	int            results_seen;
	bit            calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit hold_off();
		return !calm && ($urandom_range(99) < 29);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t result %0d: %s", $time, results_seen, what);
	endtask

	// ---------------- character classes ----------------

	function automatic logic [7:0] byte_at(logic [63:0] w, int i);
		return w[8*i +: 8];
	endfunction

	function automatic int delim_span(output logic [63:0] set);
		int n;
		set = tok_cfg.delim_set;
		n = tok_cfg.delim_count;
		if (n == 0) begin
			set = bat_pkg::DEFAULT_DELIMS;
			n = bat_pkg::DEFAULT_DELIM_COUNT;
		end
		return (n > bat_pkg::MAX_DELIMITERS) ? bat_pkg::MAX_DELIMITERS : n;
	endfunction

	function automatic int quote_span();
		return (tok_cfg.quote_count > 4) ? 4 : tok_cfg.quote_count;
	endfunction

	function automatic int pair_span();
		return (tok_cfg.pair_count > 4) ? 4 : tok_cfg.pair_count;
	endfunction

	function automatic bit delim_hit(logic [7:0] c);
		logic [63:0] set;
		int n;
		n = delim_span(set);
		if (c == 8'h00)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (byte_at(set, i) == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit quote_hit(logic [7:0] c);
		int n;
		n = quote_span();
		if (c == 8'h00)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (byte_at(tok_cfg.quote_set, i) == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// lowest byte position among the bracket pairs, or -1
	function automatic int bracket_slot(logic [7:0] c);
		int n;
		n = 2 * pair_span();
		if (c == 8'h00)
			return -1;
		for (int i = 0; i < n; i++)
			if (byte_at(tok_cfg.bracket_pairs, i) == c)
				return i;
		return -1;
	endfunction

	// ---------------- parser model ----------------

	function automatic void note_result(logic [1:0] k, logic [7:0] v, int s, int e,
		logic [1:0] err);
		token_result_t r;
		r.kind = k;
		r.value = v;
		r.tstart = 16'(s);
		r.tend = 16'(e);
		r.err = err;
		r.last = 1'b0;
		beat_results.push_back(r);
	endfunction

	function automatic void raise_error(logic [1:0] code);
		note_result(bat_pkg::KIND_ERROR, '0, 0, 0, code);
		draining = 1'b1;
	endfunction

	function automatic void clear_parse();
		in_tok = 1'b0;
		quote_open = '0;
		nest_depth = 0;
		esc_wait = 1'b0;
		pos_count = 0;
		tok_start = 0;
		draining = 1'b0;
	endfunction

	function automatic void parse_byte(logic [7:0] c, int idx, bit may_defer);
		int slot;
		if (!in_tok) begin
			if (delim_hit(c))
				return;
			in_tok = 1'b1;
			tok_start = idx;
			quote_open = '0;
			nest_depth = 0;
		end
		if (c == bat_pkg::BACKSLASH && may_defer) begin
			esc_wait = 1'b1;
			return;
		end
		slot = bracket_slot(c);
		if (quote_open != 8'h00) begin
			if (c == quote_open)
				quote_open = '0;
		end else if (quote_hit(c)) begin
			quote_open = c;
		end else if (slot >= 0) begin
			if (slot % 2 == 0) begin
				if (nest_depth >= NEST) begin
					raise_error(bat_pkg::ERR_TOO_DEEP);
					return;
				end
				nest_stack[nest_depth] = 2'(slot / 2);
				nest_depth++;
			end else begin
				// closers match on the opener byte, not on the pair index
				if (nest_depth == 0 || byte_at(tok_cfg.bracket_pairs,
						2 * nest_stack[nest_depth - 1]) !=
						byte_at(tok_cfg.bracket_pairs, slot - 1)) begin
					raise_error(bat_pkg::ERR_UNMATCHED);
					return;
				end
				nest_depth--;
			end
		end
		if (nest_depth == 0 && quote_open == 8'h00 && delim_hit(c)) begin
			note_result(bat_pkg::KIND_END, '0, tok_start, idx, '0);
			in_tok = 1'b0;
			return;
		end
		note_result(bat_pkg::KIND_CHAR, c, 0, 0, '0);
	endfunction

	// expected results of one accepted beat
	function automatic void tokenize_byte(logic [7:0] c, bit eos);
		int idx;
		int bs_idx;
		token_result_t tail;
		idx = pos_count;
		bs_idx = (idx >= bat_pkg::POS_LIMIT) ? int'(bat_pkg::POS_LIMIT) :
			((idx == 0) ? 0 : idx - 1);
		if (pos_count < bat_pkg::POS_LIMIT)
			pos_count++;
		beat_results.delete();
		if (!draining) begin
			if (esc_wait) begin
				esc_wait = 1'b0;
				if (c == bat_pkg::BACKSLASH || quote_hit(c) || bracket_slot(c) >= 0 ||
						delim_hit(c)) begin
					if (quote_open != 8'h00)
						note_result(bat_pkg::KIND_CHAR, bat_pkg::BACKSLASH, 0, 0, '0);
					note_result(bat_pkg::KIND_CHAR, c, 0, 0, '0);
				end else begin
					parse_byte(bat_pkg::BACKSLASH, bs_idx, 1'b0);
					if (!draining)
						parse_byte(c, idx, !eos);
				end
			end else begin
				parse_byte(c, idx, !eos);
			end
			if (eos && !draining && in_tok) begin
				if (quote_open != 8'h00)
					note_result(bat_pkg::KIND_ERROR, '0, 0, 0, bat_pkg::ERR_OPEN_QUOTE);
				else if (nest_depth != 0)
					note_result(bat_pkg::KIND_ERROR, '0, 0, 0, bat_pkg::ERR_OPEN_BRACKET);
				else
					note_result(bat_pkg::KIND_END, '0, tok_start, pos_count, '0);
			end
		end
		if (eos)
			clear_parse();
		if (beat_results.size() != 0) begin
			tail = beat_results[beat_results.size() - 1];
			tail.last = 1'b1;
			beat_results[beat_results.size() - 1] = tail;
		end
		foreach (beat_results[i])
			token_results_due.push_back(beat_results[i]);
	endfunction

	// ---------------- drivers ----------------

	task automatic send_char(input logic [7:0] c, input bit eos);
		if (hold_off()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (hold_off());
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall);
		tokenize_byte(c, eos);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_string_bytes();
		foreach (string_bytes[i])
			send_char(string_bytes[i], i == string_bytes.size() - 1);
	endtask

	// input idle until every due result is out and any no-result byte has cleared
	task automatic wait_drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (token_results_due.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input bat_pkg::cfg_t c);
		write_reg(bat_pkg::REG_DELIM_SET, c.delim_set);
		write_reg(bat_pkg::REG_DELIM_COUNT, 64'(c.delim_count));
		write_reg(bat_pkg::REG_BRACKETS, c.bracket_pairs);
		write_reg(bat_pkg::REG_PAIR_COUNT, 64'(c.pair_count));
		write_reg(bat_pkg::REG_QUOTE_SET, 64'(c.quote_set));
		write_reg(bat_pkg::REG_QUOTE_COUNT, 64'(c.quote_count));
		cfg_wr_en <= 1'b0;
		tok_cfg = c;
	endtask

	// ---------------- result checking ----------------

	task automatic check_result();
		token_result_t want;
		results_seen++;
		if (token_results_due.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, kind %0d value %02h", kind, value));
			return;
		end
		want = token_results_due.pop_front();
		if (kind !== want.kind)
			report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
		if (value !== want.value)
			report_mismatch($sformatf("value %02h, want %02h", value, want.value));
		if (token_start !== want.tstart)
			report_mismatch($sformatf("token_start %0d, want %0d", token_start, want.tstart));
		if (token_end !== want.tend)
			report_mismatch($sformatf("token_end %0d, want %0d", token_end, want.tend));
		if (error_code !== want.err)
			report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
		if (last_of_run !== want.last)
			report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		out_stall <= hold_off();
	end

	// ---------------- string generation ----------------

	function automatic logic [7:0] plain_byte();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] some_delim();
		logic [63:0] set;
		int n;
		n = delim_span(set);
		return byte_at(set, $urandom_range(n - 1));
	endfunction

	function automatic logic [7:0] some_quote();
		int n;
		n = quote_span();
		if (n == 0)
			return 8'h22;
		return byte_at(tok_cfg.quote_set, $urandom_range(n - 1));
	endfunction

	function automatic void some_pair(output logic [7:0] op, output logic [7:0] cl);
		int p;
		if (pair_span() == 0) begin
			op = 8'h28;
			cl = 8'h29;
			return;
		end
		p = $urandom_range(pair_span() - 1);
		op = byte_at(tok_cfg.bracket_pairs, 2 * p);
		cl = byte_at(tok_cfg.bracket_pairs, 2 * p + 1);
	endfunction

	// mostly balanced strings with random content; some broken on purpose
	function automatic void build_string();
		logic [7:0] closers[$];
		logic [7:0] op;
		logic [7:0] cl;
		logic [7:0] q;
		string_bytes.delete();
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) string_bytes.push_back(some_delim());
		if ($urandom_range(7) == 0) begin
			// nest right up to the stack limit, sometimes past it
			string_bytes.push_back(plain_byte());
			repeat ($urandom_range(NEST - 2, NEST + 2)) begin
				some_pair(op, cl);
				string_bytes.push_back(op);
				closers.push_front(cl);
			end
		end
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(9))
				0, 1, 2: repeat ($urandom_range(1, 4)) string_bytes.push_back(plain_byte());
				3: repeat ($urandom_range(1, 2)) string_bytes.push_back(some_delim());
				4: begin
					some_pair(op, cl);
					string_bytes.push_back(op);
					closers.push_front(cl);
				end
				5: begin
					if (closers.size() != 0) begin
						string_bytes.push_back(closers.pop_front());
					end else begin
						some_pair(op, cl);
						string_bytes.push_back(cl);
					end
				end
				6: begin
					q = some_quote();
					string_bytes.push_back(q);
					repeat ($urandom_range(0, 3)) begin
						case ($urandom_range(2))
							0: string_bytes.push_back(plain_byte());
							1: string_bytes.push_back(some_delim());
							default: begin
								string_bytes.push_back(bat_pkg::BACKSLASH);
								string_bytes.push_back(q);
							end
						endcase
					end
					if ($urandom_range(7) != 0)
						string_bytes.push_back(q);
				end
				7: begin
					string_bytes.push_back(bat_pkg::BACKSLASH);
					some_pair(op, cl);
					case ($urandom_range(5))
						0: string_bytes.push_back(bat_pkg::BACKSLASH);
						1: string_bytes.push_back(some_quote());
						2: string_bytes.push_back(op);
						3: string_bytes.push_back(cl);
						4: string_bytes.push_back(some_delim());
						default: string_bytes.push_back(plain_byte());
					endcase
				end
				8: string_bytes.push_back(8'($urandom_range(255)));
				default: begin
					string_bytes.push_back(plain_byte());
					string_bytes.push_back(some_delim());
				end
			endcase
		end
		if ($urandom_range(7) != 0)
			while (closers.size() != 0)
				string_bytes.push_back(closers.pop_front());
		if ($urandom_range(14) == 0)
			string_bytes.push_back(bat_pkg::BACKSLASH);
	endfunction

	task automatic send_random_strings(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_string();
			send_string_bytes();
			sent += string_bytes.size();
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_directed_cases();
		load_config(bat_pkg::cfg_t'{bat_pkg::DELIM_SET_RST, bat_pkg::DELIM_COUNT_RST,
			bat_pkg::BRACKET_RST, bat_pkg::PAIR_COUNT_RST, bat_pkg::QUOTE_RST,
			bat_pkg::QUOTE_COUNT_RST});
		send_text("  a\\ b");       // leading delimiters, escaped delimiter
		send_text("\"x\\\" \"");    // escaped quote inside quotes keeps the backslash
		send_text("a)b c");         // unmatched closer, rest dropped
		send_text("(a");            // unclosed bracket
		send_text("\"a");           // unclosed quote
		send_text("q\\");           // backslash as last byte
		send_text("\\q");           // backslash before an ordinary byte
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		wait_drain();
	endtask

	task automatic test_default_sets();
		send_random_strings(PHASE_BYTES / 2);
		wait_drain();
		send_random_strings(PHASE_BYTES / 2);
		wait_drain();
	endtask

	// four pairs, three quotes, zero byte inside the delimiter set
	task automatic test_wide_sets();
		load_config(bat_pkg::cfg_t'{64'h0000_0020_7C3B_002C, 4'd5, 64'h3E3C_7D7B_5D5B_2928,
			3'd4, 32'h0060_2722, 3'd3});
		calm = 1'b1;
		send_random_strings(PHASE_BYTES);
		calm = 1'b0;
		wait_drain();
	endtask

	// counts past the maximum, repeated bracket bytes, two pairs sharing an opener
	task automatic test_saturated_counts();
		load_config(bat_pkg::cfg_t'{64'hFF7C_2F2E_3A3B_2C20, 4'd15, 64'h7D7B_5D28_285B_2928,
			3'd7, 32'hFF27_0022, 3'd7});
		send_random_strings(PHASE_BYTES);
		wait_drain();
	endtask

	// delimiter count zero falls back to the default set; no brackets, no quotes
	task automatic test_empty_sets();
		load_config(bat_pkg::cfg_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0, 3'd0,
			32'hFFFF_FFFF, 3'd0});
		send_random_strings(PHASE_BYTES);
		wait_drain();
	endtask

	// closer doubles as delimiter, backslash is a delimiter, all-ones quote byte
	task automatic test_shared_roles();
		load_config(bat_pkg::cfg_t'{64'h0000_0000_005C_2029, 4'd3, 64'h0000_0000_5D5B_2928,
			3'd2, 32'h0027_FF22, 3'd4});
		send_random_strings(PHASE_BYTES);
		wait_drain();
	endtask

	// token offsets around late-resolved backslashes
	task automatic test_late_offsets();
		load_config(bat_pkg::cfg_t'{bat_pkg::DELIM_SET_RST, bat_pkg::DELIM_COUNT_RST,
			bat_pkg::BRACKET_RST, bat_pkg::PAIR_COUNT_RST, bat_pkg::QUOTE_RST,
			bat_pkg::QUOTE_COUNT_RST});
		calm = 1'b1;
		repeat (5) send_char(8'h20, 1'b0);
		send_text("ab\\qc x\\y z");
		calm = 1'b0;
		wait_drain();
	endtask

	initial begin
		mismatches = 0;
		results_seen = 0;
		calm = 1'b0;
		clear_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_default_sets();
		test_wide_sets();
		test_saturated_counts();
		test_empty_sets();
		test_shared_roles();
		test_late_offsets();
		wait_drain();
		if (token_results_due.size() != 0)
			report_mismatch($sformatf("%0d results never came", token_results_due.size()));
		if (mismatches == 0)
			$display("bracket_aware_tokenizer_unit: match");
		else
			$display("bracket_aware_tokenizer_unit: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("bracket_aware_tokenizer_unit: mismatch");
		$finish;
	end

endmodule
